@@ hw/rtl/ssic_pkg.sv @@
package ssic_pkg;

  // Width of the one-based index along the walk
  localparam int INDEX_BITS = 48;
  // Root digits: one cell per digit
  localparam int ROOT_BITS  = (INDEX_BITS + 1) / 2;
  // Radicand padded to an even number of bits
  localparam int RAD_BITS   = 2 * ROOT_BITS;
  // Partial remainder width (remainder never exceeds twice the root)
  localparam int REM_BITS   = ROOT_BITS + 2;
  // Coordinate field width
  localparam int COORD_BITS = 25;
  // Width used for the coordinate arithmetic before truncation
  localparam int CALC_BITS  = (REM_BITS > COORD_BITS) ? REM_BITS : COORD_BITS;

  // Data handed from one root cell to the next
  typedef struct packed {
    logic                vld;
    logic [RAD_BITS-1:0] rad;
    logic [REM_BITS-1:0] rem;
    logic [ROOT_BITS-1:0] root;
  } ssic_cell_t;

endpackage

@@ hw/rtl/ssic_cell.sv @@
module ssic_cell
  import ssic_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  ssic_cell_t cell_in,
  output ssic_cell_t cell_out
);

  logic                 vld_r;
  logic [RAD_BITS-1:0]  rad_r;
  logic [REM_BITS-1:0]  rem_r;
  logic [ROOT_BITS-1:0] root_r;

  logic [RAD_BITS-1:0]  rad_nxt;
  logic [REM_BITS-1:0]  rem_nxt;
  logic [ROOT_BITS-1:0] root_nxt;
  logic [REM_BITS-1:0]  rem_sh;
  logic [REM_BITS-1:0]  trial;

  // Bring down the next two radicand bits and try root*4+1
  always_comb begin
    rem_sh  = {cell_in.rem[REM_BITS-3:0], cell_in.rad[RAD_BITS-1:RAD_BITS-2]};
    trial   = {cell_in.root, 2'b01};
    rad_nxt = {cell_in.rad[RAD_BITS-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {cell_in.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {cell_in.root[ROOT_BITS-2:0], 1'b0};
    end
  end

  // Track occupancy of this cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= cell_in.vld;
    end
  end

  // Advance the digit data with the chain
  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign cell_out = '{vld: vld_r, rad: rad_r, rem: rem_r, root: root_r};

  // Remainder of a partial root stays at most twice that root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> ({1'b0, rem_r} <= {2'b00, root_r, 1'b0}))
    else $error("partial remainder exceeds twice the partial root");

  // A stalled chain holds every cell
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !adv) |=> ($stable(vld_r) && $stable(rem_r) && $stable(root_r)))
    else $error("cell changed while the chain was stalled");

endmodule

@@ hw/rtl/ssic_coord.sv @@
module ssic_coord
  import ssic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  ssic_cell_t            cell_in,
  output logic                  vld,
  output logic [COORD_BITS-1:0] column,
  output logic [COORD_BITS-1:0] row
);

  logic                  vld_r;
  logic [COORD_BITS-1:0] col_r;
  logic [COORD_BITS-1:0] row_r;

  logic [CALC_BITS-1:0]  k;
  logic [CALC_BITS-1:0]  d;
  logic [CALC_BITS-1:0]  up;
  logic [CALC_BITS-1:0]  down;
  logic [COORD_BITS-1:0] col_nxt;
  logic [COORD_BITS-1:0] row_nxt;

  // Shell k = root+1, offset d = remainder; pick the leg of the shell
  always_comb begin
    k    = CALC_BITS'(cell_in.root) + CALC_BITS'(1);
    d    = CALC_BITS'(cell_in.rem);
    up   = d + CALC_BITS'(1);
    down = (k << 1) - CALC_BITS'(1) - d;
    if (k[0]) begin
      if (d < k) begin
        col_nxt = k[COORD_BITS-1:0];
        row_nxt = up[COORD_BITS-1:0];
      end else begin
        row_nxt = k[COORD_BITS-1:0];
        col_nxt = down[COORD_BITS-1:0];
      end
    end else begin
      if (d < k) begin
        row_nxt = k[COORD_BITS-1:0];
        col_nxt = up[COORD_BITS-1:0];
      end else begin
        col_nxt = k[COORD_BITS-1:0];
        row_nxt = down[COORD_BITS-1:0];
      end
    end
  end

  // Output register occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= cell_in.vld;
    end
  end

  // Hold coordinates until the transfer
  always_ff @(posedge clk) begin
    if (adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign vld    = vld_r;
  assign column = col_r;
  assign row    = row_r;

  // One-based coordinates are never zero
  a_coord_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (col_r != '0 && row_r != '0))
    else $error("zero coordinate produced");

endmodule

@@ hw/rtl/square_shell_index_to_coordinate_top.sv @@
// Channel | Ports                              | Transfer
// input   | in_valid in_ready in_position      | in_valid && in_ready
// result  | out_valid out_ready out_column/row | out_valid && out_ready
//
// One position enters per cycle while in_ready is high. It crosses ROOT_BITS+1
// registers: one cell per root digit, then the output stage.
// The whole chain moves as one; it stalls only while a result waits at the output.
// Reset clears the valid flags of the cells and the output stage.
// Position zero is treated as position one.
module square_shell_index_to_coordinate_top
  import ssic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INDEX_BITS-1:0] in_position,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_column,
  output logic [COORD_BITS-1:0] out_row
);

  ssic_cell_t            chain [ROOT_BITS+1];
  logic                  adv;
  logic [INDEX_BITS-1:0] pos_m1;

  // Advance the chain unless a finished result is held
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Radicand is position minus one, with zero treated as one
  assign pos_m1 = (in_position == '0) ? '0 : in_position - INDEX_BITS'(1);

  assign chain[0] = '{vld: in_valid, rad: RAD_BITS'(pos_m1), rem: '0, root: '0};

  // One cell per root digit
  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
    ssic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  ssic_coord u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cell_in (chain[ROOT_BITS]),
    .vld     (out_valid),
    .column  (out_column),
    .row     (out_row)
  );

endmodule
